FILE: sv/aunp_pkg.sv
// aunp_pkg: shared types, codes and character helpers for the ascii unsigned
// number parser. no dependencies; every other file of the block imports it.
`default_nettype none

package aunp_pkg;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned BASE_W     = 6;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned END_W      = 12;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE  = 2'd0,
    CFG_EXACT = 2'd1,
    CFG_MAX   = 2'd2
  } cfg_idx_e;

  // per-string parse phase
  typedef enum logic [2:0] {
    PH_WS      = 3'd0,
    PH_START   = 3'd1,
    PH_ZERO    = 3'd2,
    PH_ZEROX   = 3'd3,
    PH_DIGITS  = 3'd4,
    PH_TRAIL   = 3'd5,
    PH_NEG     = 3'd6,
    PH_BADBASE = 3'd7
  } phase_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_RANGE   = 2'd2
  } status_e;

  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
  localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
  localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;

  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CH_W-1:0] CH_UP_X  = 8'h58;
  localparam logic [CH_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CH_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CH_W-1:0] CH_LO_X  = 8'h78;
  localparam logic [CH_W-1:0] CH_LO_Z  = 8'h7A;
  localparam logic [CH_W-1:0] NO_DIGIT = 8'hFF;
  localparam logic [CH_W-1:0] LETTER_OFS = 8'd10;

  typedef struct packed {
    logic [BASE_W-1:0]     base;
    logic                  exact;
    logic [CFG_DATA_W-1:0] bound;
  } cfg_t;

  typedef struct packed {
    status_e          status;
    logic [END_W-1:0] end_index;
  } res_info_t;

  // digit value of a character in radix 36, NO_DIGIT otherwise
  function automatic logic [CH_W-1:0] digit_of(input logic [CH_W-1:0] c);
    logic [CH_W-1:0] d;
    d = NO_DIGIT;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      d = c - CH_LO_A + LETTER_OFS;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      d = c - CH_UP_A + LETTER_OFS;
    end
    return d;
  endfunction

  function automatic logic is_space(input logic [CH_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

`default_nettype wire

FILE: sv/aunp_if.sv
// aunp_if: valid/ready channel interfaces of the ascii number parser, one for
// the byte stream and one for results. depends on aunp_pkg.
`default_nettype none

interface aunp_byte_if
  import aunp_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface aunp_result_if
  import aunp_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 64
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic [STATUS_W-1:0]   status;
  logic [END_W-1:0]      end_index;

  modport source (output valid, output value, output status, output end_index, input ready);
  modport sink   (input valid, input value, input status, input end_index, output ready);
endinterface

`default_nettype wire

FILE: sv/aunp_mac.sv
// aunp_mac: one radix step acc * base + digit with overflow detection.
// depends on aunp_pkg.
`default_nettype none

module aunp_mac
  import aunp_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire logic [VALUE_BITS-1:0] acc_i,
  input  wire logic [BASE_W-1:0]     base_i,
  input  wire logic [BASE_W-1:0]     digit_i,
  output logic      [VALUE_BITS-1:0] sum_o,
  output logic                       ovf_o
);

  // acc * 63 + 63 still fits in VALUE_BITS + BASE_W bits
  localparam int unsigned PW = VALUE_BITS + BASE_W;

  logic [BASE_W-1:0] mult_base;
  logic [PW-1:0]     full;

  // bases below two multiply as two
  assign mult_base = (base_i < BASE_MIN) ? BASE_MIN : base_i;
  assign full      = PW'(acc_i) * PW'(mult_base) + PW'(digit_i);
  assign sum_o     = full[VALUE_BITS-1:0];
  assign ovf_o     = |full[PW-1:VALUE_BITS];

endmodule

`default_nettype wire

FILE: sv/aunp_parse_fsm.sv
// aunp_parse_fsm: per-string parse state, one byte per step, and the result
// fields for a terminating byte. depends on aunp_pkg and aunp_mac.
`default_nettype none

module aunp_parse_fsm
  import aunp_pkg::*;
#(
  parameter int unsigned VALUE_BITS  = 64,
  parameter int unsigned INDEX_LIMIT = 4095
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire logic [CH_W-1:0]       ch_i,
  input  wire cfg_t                  cfg_i,
  output logic      [VALUE_BITS-1:0] value_o,
  output res_info_t                  info_o
);

  localparam int unsigned IW = $clog2(INDEX_LIMIT + 1);
  localparam logic [IW-1:0] IDX_MAX = IW'(INDEX_LIMIT);

  phase_e                phase_q, phase_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic [BASE_W-1:0]     wbase_q, wbase_d;
  logic                  ovf_q, ovf_d;
  logic                  dseen_q, dseen_d;
  logic [IW-1:0]         bidx_q, bidx_d;
  logic [IW-1:0]         sidx_q, sidx_d;
  logic                  trail_q, trail_d;

  logic [CH_W-1:0]       dig;
  logic                  acc_go, stop_go, mark_go, trail_force, start_go, take_go;
  logic [BASE_W-1:0]     acc_dig;
  logic [VALUE_BITS-1:0] mac_sum;
  logic                  mac_ovf;
  logic                  term;
  logic [IW-1:0]         end_idx;

  assign term = (ch_i == CH_NUL);

  // phase decision for this byte
  always_comb begin
    dig         = digit_of(ch_i);
    phase_d     = phase_q;
    wbase_d     = wbase_q;
    acc_go      = 1'b0;
    acc_dig     = dig[BASE_W-1:0];
    stop_go     = 1'b0;
    mark_go     = 1'b0;
    trail_force = 1'b0;
    start_go    = 1'b0;
    take_go     = 1'b0;
    unique case (phase_q)
      PH_WS: begin
        if (!is_space(ch_i)) begin
          if (cfg_i.base == BASE_MIN - 6'd1 || cfg_i.base > BASE_MAX) begin
            phase_d = PH_BADBASE;
          end else begin
            wbase_d = cfg_i.base;
            if (ch_i == CH_PLUS) begin
              phase_d = PH_START;
            end else if (ch_i == CH_MINUS) begin
              mark_go = 1'b1;
              phase_d = PH_NEG;
            end else begin
              start_go = 1'b1;
            end
          end
        end
      end
      PH_START: start_go = 1'b1;
      PH_ZERO: begin
        if (ch_i == CH_LO_X || ch_i == CH_UP_X) begin
          mark_go = 1'b1;
          phase_d = PH_ZEROX;
        end else begin
          if (wbase_q == BASE_AUTO) wbase_d = BASE_OCT;
          phase_d = PH_DIGITS;
          take_go = 1'b1;
        end
      end
      PH_ZEROX: begin
        if (dig < CH_W'(BASE_HEX)) begin
          wbase_d = BASE_HEX;
          phase_d = PH_DIGITS;
          take_go = 1'b1;
        end else begin
          trail_force = 1'b1;
          phase_d     = PH_TRAIL;
        end
      end
      PH_DIGITS: take_go = 1'b1;
      default: ;
    endcase
    // first significant byte: a leading zero may open a prefix
    if (start_go) begin
      if ((wbase_d == BASE_AUTO || wbase_d == BASE_HEX) && ch_i == CH_ZERO) begin
        acc_go  = 1'b1;
        acc_dig = '0;
        phase_d = PH_ZERO;
      end else begin
        if (wbase_d == BASE_AUTO) wbase_d = BASE_DEC;
        phase_d = PH_DIGITS;
        take_go = 1'b1;
      end
    end
    // digit of the radix or the stop byte
    if (take_go) begin
      if (dig < CH_W'(wbase_d)) begin
        acc_go = 1'b1;
      end else begin
        stop_go = 1'b1;
        phase_d = PH_TRAIL;
      end
    end
  end

  aunp_mac #(
    .VALUE_BITS (VALUE_BITS)
  ) u_mac (
    .acc_i   (acc_q),
    .base_i  (wbase_d),
    .digit_i (acc_dig),
    .sum_o   (mac_sum),
    .ovf_o   (mac_ovf)
  );

  always_comb begin
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    dseen_d = dseen_q;
    sidx_d  = sidx_q;
    trail_d = trail_q;
    bidx_d  = (bidx_q < IDX_MAX) ? IW'(bidx_q + 1'b1) : bidx_q;
    if (acc_go) begin
      dseen_d = 1'b1;
      if (!ovf_q) begin
        if (mac_ovf) begin
          ovf_d = 1'b1;
          acc_d = '1;
        end else begin
          acc_d = mac_sum;
        end
      end
    end
    if (mark_go) sidx_d = bidx_q;
    if (stop_go) begin
      sidx_d  = bidx_q;
      trail_d = !term;
    end
    if (trail_force) trail_d = 1'b1;
  end

  // result of a terminating byte; no digit is taken on it, so acc_q is final
  always_comb begin
    value_o        = '0;
    info_o.status  = ST_OK;
    end_idx        = '0;
    priority if (phase_d == PH_BADBASE) begin
      info_o.status = ST_INVALID;
    end else if (phase_d == PH_NEG) begin
      info_o.status = ST_INVALID;
      end_idx       = sidx_d;
    end else if (!dseen_q) begin
      info_o.status = ST_INVALID;
    end else if (ovf_q) begin
      info_o.status = ST_RANGE;
      value_o       = '1;
      end_idx       = sidx_d;
    end else begin
      end_idx = sidx_d;
      if (cfg_i.exact && trail_d) begin
        info_o.status = ST_INVALID;
      end else begin
        value_o = acc_q;
        if (cfg_i.exact && CFG_DATA_W'(acc_q) > cfg_i.bound) info_o.status = ST_RANGE;
      end
    end
    info_o.end_index = END_W'(end_idx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WS;
      acc_q   <= '0;
      wbase_q <= '0;
      ovf_q   <= 1'b0;
      dseen_q <= 1'b0;
      bidx_q  <= '0;
      sidx_q  <= '0;
      trail_q <= 1'b0;
    end else if (step_i) begin
      if (term) begin
        phase_q <= PH_WS;
        acc_q   <= '0;
        wbase_q <= '0;
        ovf_q   <= 1'b0;
        dseen_q <= 1'b0;
        bidx_q  <= '0;
        sidx_q  <= '0;
        trail_q <= 1'b0;
      end else begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        wbase_q <= wbase_d;
        ovf_q   <= ovf_d;
        dseen_q <= dseen_d;
        bidx_q  <= bidx_d;
        sidx_q  <= sidx_d;
        trail_q <= trail_d;
      end
    end
  end

  a_clear_after_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && term |=> phase_q == PH_WS && bidx_q == '0 && !dseen_q)
    else $error("string state not cleared after terminator");

  a_ovf_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> acc_q == {VALUE_BITS{1'b1}})
    else $error("overflow without saturated value");

  a_no_digit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !dseen_q |-> acc_q == '0)
    else $error("value accumulated without a digit");

endmodule

`default_nettype wire

FILE: sv/ascii_unsigned_number_parser_core.sv
// ascii_unsigned_number_parser_core: top level of the strtoul-style parser,
// with config registers, input register and result register.
// depends on aunp_pkg, aunp_if and aunp_parse_fsm.
`default_nettype none

// The core parses a stream of ASCII bytes, one byte per transaction on
// byte_in, into an unsigned number. A string ends with byte 0, and only that
// byte yields a transaction on result_out (value, status, end_index). Leading
// whitespace is skipped, a '+' is accepted, a '-' gives status invalid. Base 0
// detects hex ("0x" plus a hex digit), octal (leading 0) or decimal; base 16
// skips an "0x" prefix. Overflow saturates the value to all ones with status
// out of range. In exact mode trailing bytes give invalid, and a value above
// the upper bound register gives out of range. One byte is taken every clock
// cycle while the byte stream does not stall: the parse state is updated by
// one multiply-add with overflow detection, and the result register takes
// its result when a terminator steps out of the input register. The byte
// stream stalls only when a terminator waits in the input register while an
// earlier result has not been taken. Config writes (cfg_we_i, cfg_index_i,
// cfg_data_i) should be made while no string is in flight; the base is
// sampled at the first significant byte, exact mode and the upper bound at
// the terminator.

module ascii_unsigned_number_parser_core
  import aunp_pkg::*;
#(
  parameter int unsigned VALUE_BITS  = 64,
  parameter int unsigned INDEX_LIMIT = 4095
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  aunp_byte_if.sink                  byte_in,
  aunp_result_if.source              result_out
);

  // configuration registers
  logic [BASE_W-1:0]     base_q;
  logic                  exact_q;
  logic [CFG_DATA_W-1:0] max_q;
  cfg_t                  cfg;

  // input register
  logic                  in_valid_q;
  logic [CH_W-1:0]       ch_q;
  logic                  term_q;
  logic                  step;
  logic                  in_take;

  // result register
  logic                  out_valid_q;
  logic [VALUE_BITS-1:0] value_q;
  res_info_t             info_q;
  logic                  out_free;
  logic                  out_load;

  logic [VALUE_BITS-1:0] fsm_value;
  res_info_t             fsm_info;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BASE_RESET;
      exact_q <= 1'b0;
      max_q   <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BASE:  base_q  <= cfg_data_i[BASE_W-1:0];
        CFG_EXACT: exact_q <= cfg_data_i[0];
        CFG_MAX:   max_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg.base  = base_q;
  assign cfg.exact = exact_q;
  assign cfg.bound = max_q;

  // a terminator may only step when the result register can take its result
  assign term_q        = (ch_q == CH_NUL);
  assign out_free      = !out_valid_q || result_out.ready;
  assign step          = in_valid_q && (!term_q || out_free);
  assign byte_in.ready = !in_valid_q || step;
  assign in_take       = byte_in.valid && byte_in.ready;
  assign out_load      = step && term_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      ch_q <= byte_in.ch;
    end
  end

  aunp_parse_fsm #(
    .VALUE_BITS  (VALUE_BITS),
    .INDEX_LIMIT (INDEX_LIMIT)
  ) u_fsm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .ch_i    (ch_q),
    .cfg_i   (cfg),
    .value_o (fsm_value),
    .info_o  (fsm_info)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (result_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      value_q <= fsm_value;
      info_q  <= fsm_info;
    end
  end

  assign result_out.valid     = out_valid_q;
  assign result_out.value     = value_q;
  assign result_out.status    = info_q.status;
  assign result_out.end_index = info_q.end_index;

  // invalid results carry a zero value
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_out.valid && result_out.status == ST_INVALID |-> result_out.value == '0)
    else $error("invalid result with nonzero value");

  // a blocked terminator stays in the input register
  a_term_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && term_q && out_valid_q && !result_out.ready |=> in_valid_q && term_q)
    else $error("terminator lost while result blocked");

  // ordinary bytes never wait on the result side
  a_byte_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !term_q |-> byte_in.ready)
    else $error("non-terminator byte stalled");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> result_out.valid)
    else $error("terminator stepped without a result");

endmodule

`default_nettype wire

FILE: verif/tb_ascii_unsigned_number_parser_core.sv
`timescale 1ns / 100ps
// tb_ascii_unsigned_number_parser_core: self-checking bench for the ascii
// unsigned number parser, a table of directed strings, then random strings.
// depends on aunp_pkg, aunp_if and ascii_unsigned_number_parser_core.

module tb_ascii_unsigned_number_parser_core;
  import aunp_pkg::*;

  localparam int unsigned VAL_W        = 64;
  localparam int unsigned IDX_CAP      = 4095;
  localparam int unsigned DIR_ROWS     = 25;
  localparam int unsigned RAND_PHASES  = 8;
  localparam int unsigned PHASE_BYTES  = 52;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam logic [VAL_W-1:0] ALL_ONES = {VAL_W{1'b1}};

  typedef logic [CH_W-1:0] chars_t [$];

  typedef struct packed {
    logic [VAL_W-1:0] value;
    status_e          status;
    logic [END_W-1:0] end_index;
  } parse_result_t;

  // a result typed into the directed table, or known == 0 to use the predictor
  typedef struct packed {
    logic          known;
    parse_result_t res;
  } pinned_t;

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic              exact;
    logic [VAL_W-1:0]  bound;
    logic [12:0]       pad;     // leading '0' bytes in front of the text
    logic              known;
    logic [VAL_W-1:0]  value;
    status_e           status;
    logic [END_W-1:0]  end_index;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  aunp_byte_if                          byte_ch ();
  aunp_result_if #(.VALUE_BITS(VAL_W))  res_ch ();

  ascii_unsigned_number_parser_core #(
    .VALUE_BITS  (VAL_W),
    .INDEX_LIMIT (IDX_CAP)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .byte_in     (byte_ch),
    .result_out  (res_ch)
  );

  always #4 clk_i = ~clk_i;

  // shadow of the configuration registers, updated after each write
  logic [BASE_W-1:0] cfg_base  = BASE_RESET;
  logic              cfg_exact = 1'b0;
  logic [VAL_W-1:0]  cfg_max   = ALL_ONES;

  // per-string scan state of the predictor
  phase_e           scan_phase  = PH_WS;
  logic [VAL_W-1:0] scan_acc    = '0;
  logic [BASE_W-1:0] scan_radix = '0;
  logic             scan_ovf    = 1'b0;
  logic             scan_digits = 1'b0;
  logic [END_W-1:0] scan_pos    = '0;
  logic [END_W-1:0] scan_stop   = '0;
  logic             scan_trail  = 1'b0;

  parse_result_t pending_results [$];   // results still owed by the parser
  pinned_t       pinned_results  [$];   // one entry per terminator sent

  int unsigned src_idle = 22;
  int unsigned snk_idle = 46;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // directed strings: extremes, whitespace set, signs, prefixes, radix
  // extremes, bad radix, exact-mode checks and a long run of leading zeros
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{BASE_DEC, 1'b0, ALL_ONES, 13'd0, 1'b1, 64'd0, ST_INVALID, 12'd0},
    '{BASE_DEC, 1'b0, ALL_ONES, 13'd0, 1'b1, 64'd0, ST_OK, 12'd1},
    '{BASE_DEC, 1'b0, ALL_ONES, 13'd0, 1'b1, ALL_ONES, ST_OK, 12'd20},
    '{BASE_DEC, 1'b0, ALL_ONES, 13'd0, 1'b1, ALL_ONES, ST_RANGE, 12'd20},
    '{BASE_DEC, 1'b0, ALL_ONES, 13'd0, 1'b1, 64'd7, ST_OK, 12'd7},
    '{BASE_DEC, 1'b0, ALL_ONES, 13'd0, 1'b1, 64'd0, ST_INVALID, 12'd1},
    '{BASE_DEC, 1'b0, ALL_ONES, 13'd0, 1'b1, 64'd0, ST_INVALID, 12'd0},
    '{BASE_DEC, 1'b0, ALL_ONES, 13'd0, 1'b0, 64'd0, ST_OK, 12'd0},
    '{BASE_DEC, 1'b0, ALL_ONES, 13'd40, 1'b1, 64'd0, ST_OK, 12'd40},
    '{BASE_AUTO, 1'b0, ALL_ONES, 13'd0, 1'b1, 64'd31, ST_OK, 12'd4},
    '{BASE_AUTO, 1'b0, ALL_ONES, 13'd0, 1'b1, 64'd0, ST_OK, 12'd1},
    '{BASE_AUTO, 1'b0, ALL_ONES, 13'd0, 1'b1, 64'd15, ST_OK, 12'd3},
    '{BASE_AUTO, 1'b0, ALL_ONES, 13'd0, 1'b0, 64'd0, ST_OK, 12'd0},
    '{BASE_AUTO, 1'b0, ALL_ONES, 13'd0, 1'b0, 64'd0, ST_OK, 12'd0},
    '{BASE_AUTO, 1'b0, ALL_ONES, 13'd0, 1'b0, 64'd0, ST_OK, 12'd0},
    '{BASE_HEX, 1'b0, ALL_ONES, 13'd0, 1'b1, ALL_ONES, ST_OK, 12'd18},
    '{BASE_HEX, 1'b0, ALL_ONES, 13'd0, 1'b0, 64'd0, ST_OK, 12'd0},
    '{BASE_MIN, 1'b0, ALL_ONES, 13'd0, 1'b0, 64'd0, ST_OK, 12'd0},
    '{BASE_MAX, 1'b0, ALL_ONES, 13'd0, 1'b0, 64'd0, ST_OK, 12'd0},
    '{6'd1, 1'b0, ALL_ONES, 13'd0, 1'b1, 64'd0, ST_INVALID, 12'd0},
    '{6'd63, 1'b0, ALL_ONES, 13'd0, 1'b1, 64'd0, ST_INVALID, 12'd0},
    '{BASE_DEC, 1'b1, 64'd100, 13'd0, 1'b1, 64'd101, ST_RANGE, 12'd3},
    '{BASE_DEC, 1'b1, 64'd100, 13'd0, 1'b1, 64'd0, ST_INVALID, 12'd2},
    '{BASE_DEC, 1'b1, 64'd0, 13'd0, 1'b1, 64'd0, ST_OK, 12'd1},
    '{BASE_DEC, 1'b1, 64'd0, 13'd0, 1'b0, 64'd0, ST_OK, 12'd0}
  };

  string dir_text [DIR_ROWS] = '{
    "", "0", "18446744073709551615", "18446744073709551616",
    "\011\012\013\014\015 7", " -5", "+", "  +42abc", "",
    "0x1F", "0xg", "017", "08", "0X", " 123",
    "0xFFFFFFFFFFFFFFFF", "+ff", "1012", "zZ",
    "5", " 9",
    "101", "12x", "0", "5 "
  };

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  function automatic logic [CH_W-1:0] char_digit(input logic [CH_W-1:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
    if (c >= CH_LO_A && c <= CH_LO_Z) return c - CH_LO_A + 8'd10;
    if (c >= CH_UP_A && c <= CH_UP_Z) return c - CH_UP_A + 8'd10;
    return NO_DIGIT;
  endfunction

  function automatic logic is_blank(input logic [CH_W-1:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // one multiply-add step; saturates and stays saturated once it overflows
  function automatic void add_digit(input logic [CH_W-1:0] d);
    logic [VAL_W-1:0] mult;
    mult = (scan_radix < BASE_MIN) ? 64'd2 : 64'(scan_radix);
    scan_digits = 1'b1;
    if (!scan_ovf) begin
      if (scan_acc > (ALL_ONES - 64'(d)) / mult) begin
        scan_ovf = 1'b1;
        scan_acc = ALL_ONES;
      end else begin
        scan_acc = scan_acc * mult + 64'(d);
      end
    end
  endfunction

  // a digit of the radix is accumulated, anything else ends the number
  function automatic void take_char(input logic [CH_W-1:0] c);
    logic [CH_W-1:0] d;
    d = char_digit(c);
    if (d < 8'(scan_radix)) begin
      add_digit(d);
    end else begin
      scan_stop  = scan_pos;
      scan_trail = (c != CH_NUL);
      scan_phase = PH_TRAIL;
    end
  endfunction

  // first byte after whitespace and sign: a '0' may open a prefix
  function automatic void lead_char(input logic [CH_W-1:0] c);
    if ((scan_radix == BASE_AUTO || scan_radix == BASE_HEX) && c == CH_ZERO) begin
      add_digit(8'd0);
      scan_phase = PH_ZERO;
    end else begin
      if (scan_radix == BASE_AUTO) scan_radix = BASE_DEC;
      scan_phase = PH_DIGITS;
      take_char(c);
    end
  endfunction

  // advance the scan by one byte; returns 1 with the result on a terminator
  function automatic logic parse_step(input logic [CH_W-1:0] c, output parse_result_t r);
    r = '0;
    case (scan_phase)
      PH_WS: begin
        if (!is_blank(c)) begin
          if (cfg_base == 6'd1 || cfg_base > BASE_MAX) begin
            scan_phase = PH_BADBASE;
          end else begin
            scan_radix = cfg_base;
            if (c == CH_PLUS) begin
              scan_phase = PH_START;
            end else if (c == CH_MINUS) begin
              scan_stop  = scan_pos;
              scan_phase = PH_NEG;
            end else begin
              lead_char(c);
            end
          end
        end
      end
      PH_START: lead_char(c);
      PH_ZERO: begin
        if (c == CH_LO_X || c == CH_UP_X) begin
          scan_stop  = scan_pos;
          scan_phase = PH_ZEROX;
        end else begin
          if (scan_radix == BASE_AUTO) scan_radix = BASE_OCT;
          scan_phase = PH_DIGITS;
          take_char(c);
        end
      end
      PH_ZEROX: begin
        // the prefix counts only when a hex digit follows it
        if (char_digit(c) < 8'd16) begin
          scan_radix = BASE_HEX;
          scan_phase = PH_DIGITS;
          take_char(c);
        end else begin
          scan_trail = 1'b1;
          scan_phase = PH_TRAIL;
        end
      end
      PH_DIGITS: take_char(c);
      default: ;
    endcase

    if (scan_pos < END_W'(IDX_CAP)) scan_pos = scan_pos + 1'b1;
    if (c != CH_NUL) return 1'b0;

    r.status = ST_OK;
    if (scan_phase == PH_BADBASE) begin
      r.status = ST_INVALID;
    end else if (scan_phase == PH_NEG) begin
      r.status    = ST_INVALID;
      r.end_index = scan_stop;
    end else if (!scan_digits) begin
      r.status = ST_INVALID;
    end else if (scan_ovf) begin
      r.status    = ST_RANGE;
      r.value     = ALL_ONES;
      r.end_index = scan_stop;
    end else begin
      r.end_index = scan_stop;
      if (cfg_exact && scan_trail) begin
        r.status = ST_INVALID;
      end else begin
        r.value = scan_acc;
        if (cfg_exact && scan_acc > cfg_max) r.status = ST_RANGE;
      end
    end

    scan_phase  = PH_WS;
    scan_acc    = '0;
    scan_radix  = '0;
    scan_ovf    = 1'b0;
    scan_digits = 1'b0;
    scan_pos    = '0;
    scan_stop   = '0;
    scan_trail  = 1'b0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // monitor: predict on every accepted byte, check every result transaction
  // ---------------------------------------------------------------------

  always @(posedge clk_i) begin : monitor
    parse_result_t got;
    parse_result_t want;
    pinned_t       pin;
    if (rst_ni) begin
      // a terminator cannot produce its result at the same edge, so the
      // byte side is handled first
      if (byte_ch.valid && byte_ch.ready) begin
        if (parse_step(byte_ch.ch, got)) begin
          pin = '0;
          if (pinned_results.size() != 0) pin = pinned_results.pop_front();
          pending_results.push_back(pin.known ? pin.res : got);
        end
      end
      if (res_ch.valid && res_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with none pending: value %h status %0d end %0d",
                   $time, res_ch.value, res_ch.status, res_ch.end_index);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (res_ch.value !== want.value) begin
            $display("%0t: value mismatch, expected %h, got %h",
                     $time, want.value, res_ch.value);
            mismatch_count++;
          end
          if (res_ch.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, res_ch.status);
            mismatch_count++;
          end
          if (res_ch.end_index !== want.end_index) begin
            $display("%0t: end_index mismatch, expected %0d, got %0d",
                     $time, want.end_index, res_ch.end_index);
            mismatch_count++;
          end
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      res_ch.ready <= rst_ni && ($urandom_range(99) >= snk_idle);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------

  // offer one byte, with random gaps before it, and wait for its transaction
  task automatic send_byte(input logic [CH_W-1:0] c);
    while ($urandom_range(99) < src_idle) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.ch    <= c;
    do @(posedge clk_i); while (!byte_ch.ready);
  endtask

  task automatic send_string(input chars_t s, input pinned_t pin);
    pinned_results.push_back(pin);
    foreach (s[k]) send_byte(s[k]);
    send_byte(CH_NUL);
  endtask

  // hold the byte stream until every result is in and the pipe has drained
  task automatic settle();
    byte_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_reg(input cfg_idx_e which, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= which;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (which)
      CFG_BASE:  cfg_base  = data[BASE_W-1:0];
      CFG_EXACT: cfg_exact = data[0];
      CFG_MAX:   cfg_max   = data;
      default: ;
    endcase
  endtask

  // write only the registers that change; caller has settled the block
  task automatic load_config(input logic [BASE_W-1:0] base, input logic exact,
                             input logic [VAL_W-1:0] bound);
    if (base != cfg_base) set_reg(CFG_BASE, 64'(base));
    if (exact != cfg_exact) set_reg(CFG_EXACT, 64'(exact));
    if (bound != cfg_max) set_reg(CFG_MAX, bound);
  endtask

  // mostly well-formed numbers in the current radix, some noise and
  // some broken strings (lone sign, minus, prefix with no hex digit)
  function automatic chars_t make_string();
    chars_t          s;
    int unsigned     pick;
    int unsigned     radix;
    int unsigned     digits;
    int unsigned     d;
    logic [CH_W-1:0] c;
    s = {};
    repeat ($urandom_range(0, 2)) begin
      pick = $urandom_range(0, 5);
      s.push_back(pick == 5 ? CH_SPACE : CH_TAB + 8'(pick));
    end
    pick = $urandom_range(99);
    if (pick < 14) begin
      repeat ($urandom_range(0, 6)) s.push_back(8'($urandom_range(1, 255)));
      return s;
    end
    if (pick < 24) begin
      case ($urandom_range(0, 3))
        0: begin
          s.push_back(CH_MINUS);
          s.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        1: begin
          s.push_back(CH_ZERO);
          s.push_back(CH_LO_X);
          s.push_back("g");
        end
        2: s.push_back(CH_PLUS);
        default: begin
          s.push_back(CH_PLUS);
          s.push_back(CH_MINUS);
        end
      endcase
      return s;
    end
    if ($urandom_range(99) < 20) s.push_back(CH_PLUS);
    radix = (cfg_base < BASE_MIN || cfg_base > BASE_MAX) ? 10 : int'(cfg_base);
    if (cfg_base == BASE_AUTO || cfg_base == BASE_HEX) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        s.push_back(CH_ZERO);
        s.push_back($urandom_range(1) ? CH_LO_X : CH_UP_X);
        radix = 16;
      end else if (pick < 55 && cfg_base == BASE_AUTO) begin
        s.push_back(CH_ZERO);
        radix = 8;
      end
    end
    // long runs can push the value into overflow
    digits = ($urandom_range(99) < 12) ? $urandom_range(16, 70) : $urandom_range(1, 8);
    repeat (digits) begin
      d = $urandom_range(0, radix - 1);
      if (d < 10) c = CH_ZERO + 8'(d);
      else c = ($urandom_range(1) ? CH_LO_A : CH_UP_A) + 8'(d - 10);
      s.push_back(c);
    end
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(1, 3)) s.push_back(8'($urandom_range(1, 255)));
    end
    return s;
  endfunction

  initial begin : stimulus
    chars_t            s;
    dir_row_t          row;
    pinned_t           pin;
    logic [BASE_W-1:0] new_base;
    logic [VAL_W-1:0]  new_max;
    int unsigned       phase_bytes;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_BASE;
    cfg_data_i    = '0;
    byte_ch.valid = 1'b0;
    byte_ch.ch    = CH_NUL;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table, the first rows run on the reset configuration
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_rows[i];
      if (row.base != cfg_base || row.exact != cfg_exact || row.bound != cfg_max) begin
        settle();
        load_config(row.base, row.exact, row.bound);
      end
      s = {};
      repeat (row.pad) s.push_back(CH_ZERO);
      for (int k = 0; k < dir_text[i].len(); k++) s.push_back(dir_text[i][k]);
      pin.known         = row.known;
      pin.res.value     = row.value;
      pin.res.status    = row.status;
      pin.res.end_index = row.end_index;
      send_string(s, pin);
    end

    // random phases, each on a new configuration; every phase change waits
    // for the block to go quiet, which also leaves the parser with no
    // results owed while the sender holds off
    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      if (p < 3) begin
        src_idle = 22;
        snk_idle = 46;
      end else if (p < 6) begin
        src_idle = 46;
        snk_idle = 22;
      end else begin
        src_idle = 0;
        snk_idle = 0;
      end
      case ($urandom_range(0, 9))
        0, 7: new_base = BASE_AUTO;
        1: new_base = BASE_MIN;
        2: new_base = BASE_OCT;
        3: new_base = BASE_DEC;
        4, 8: new_base = BASE_HEX;
        5: new_base = BASE_MAX;
        6: new_base = BASE_W'($urandom_range(2, 36));
        default: new_base = $urandom_range(1) ? 6'd1 : BASE_W'($urandom_range(37, 63));
      endcase
      case ($urandom_range(0, 3))
        0: new_max = ALL_ONES;
        1: new_max = '0;
        2: new_max = 64'($urandom_range(0, 5000));
        default: new_max = {$urandom, $urandom};
      endcase
      load_config(new_base, 1'($urandom_range(1)), new_max);
      phase_bytes = 0;
      pin = '0;
      while (phase_bytes < PHASE_BYTES) begin
        s = make_string();
        send_string(s, pin);
        phase_bytes += s.size() + 1;
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
